// ----- rtl/mrcs_pkg.sv -----
// mrcs_pkg: shared widths, register codes and the stage-1 item type for the
// max row/column sum block. No dependencies; used by every file in rtl/.
package mrcs_pkg;

  localparam int MAX_ROWS      = 256;
  localparam int MAX_COLS      = 256;
  localparam int ELEMENT_WIDTH = 32;
  localparam int SUM_W         = 40;
  localparam int IDX_W         = 8;
  localparam int CFG_W         = 9;
  localparam int CFG_IDX_W     = 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } cfg_reg_t;

  // Element sitting in stage 1 (column memory data returns here)
  typedef struct packed {
    logic                     valid;
    logic [IDX_W-1:0]         col;
    logic [IDX_W-1:0]         row;
    logic                     first_row;
    logic                     last_col;
    logic                     last_row;
    logic signed [SUM_W-1:0]  value;
  } stage_item_t;

endpackage

// ----- rtl/mrcs_col_store.sv -----
// mrcs_col_store: column-sum memory with registered read data, write-back of the
// updated sum and a bypass for back-to-back hits on one column.
// Depends on mrcs_pkg.
module mrcs_col_store import mrcs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  logic [IDX_W-1:0]        rd_col,
  input  stage_item_t             s1,
  output logic signed [SUM_W-1:0] csum
);

  logic signed [SUM_W-1:0] mem [MAX_COLS];
  logic signed [SUM_W-1:0] rd_data;
  logic signed [SUM_W-1:0] byp_data;
  logic                    byp;
  logic signed [SUM_W-1:0] base;

  // Newest copy of the column: memory, or the sum written in the read cycle
  assign base = byp ? byp_data : rd_data;
  assign csum = s1.first_row ? s1.value : base + s1.value;

  // Read port, registered data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data  <= mem[rd_col];
      byp_data <= csum;
    end
  end

  // Read collides with the write of the item ahead (single-column matrix)
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (rd_en) begin
      byp <= s1.valid && (s1.col == rd_col);
    end
  end

  // Write-back of the updated column sum
  always_ff @(posedge clk) begin
    if (s1.valid) begin
      mem[s1.col] <= csum;
    end
  end

endmodule

// ----- rtl/max_row_column_sum.sv -----
// max_row_column_sum: top level. Streams matrix elements, keeps row and column
// sums and reports the row or column with the greatest sum.
// Depends on mrcs_pkg and mrcs_col_store.
//
//   channel  | signals                                | item
//   ---------+----------------------------------------+-----------------------
//   in       | in_valid, in_ready, element_value      | one matrix element
//   out      | out_valid, out_ready, is_column,       | winner of one matrix
//            | winner_index, max_sum                  |
//   cfg      | cfg_we, cfg_index, cfg_data            | num_rows, num_cols
//
// One element per cycle while in_ready is high. Each element passes the
// position stage (column memory read) and the update stage (add, write-back,
// best compare); the last element then sets s2_final in the result stage,
// which loads the output register and raises out_valid. Only the last element of a
// matrix waits for in_ready, while the output register is held and not taken
// or a previous last element is in flight. The column memory needs no
// clearing since row 0 writes every entry.
module max_row_column_sum import mrcs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [ELEMENT_WIDTH-1:0] element_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    is_column,
  output logic [IDX_W-1:0]        winner_index,
  output logic signed [SUM_W-1:0] max_sum
);

  localparam logic [CFG_W-1:0] ROWS_MAX = CFG_W'(MAX_ROWS);
  localparam logic [CFG_W-1:0] COLS_MAX = CFG_W'(MAX_COLS);

  logic [CFG_W-1:0]        num_rows;
  logic [CFG_W-1:0]        num_cols;
  logic [CFG_W-1:0]        rows_eff;
  logic [CFG_W-1:0]        cols_eff;
  logic [IDX_W-1:0]        col_pos;
  logic [IDX_W-1:0]        row_pos;
  logic                    s0_last_col;
  logic                    s0_last_row;
  logic                    s0_fire;
  stage_item_t             s1;
  logic                    s1_final;
  logic                    s2_final;
  logic signed [SUM_W-1:0] csum;
  logic signed [SUM_W-1:0] row_acc;
  logic signed [SUM_W-1:0] acc_new;
  logic signed [SUM_W-1:0] best_row_sum;
  logic [IDX_W-1:0]        best_row_index;
  logic signed [SUM_W-1:0] best_col_sum;
  logic [IDX_W-1:0]        best_col_index;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= CFG_W'(4);
      num_cols <= CFG_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NUM_ROWS: num_rows <= cfg_data;
        REG_NUM_COLS: num_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sizes clamped to 1..max
  always_comb begin
    rows_eff = num_rows;
    if (num_rows == '0)      rows_eff = CFG_W'(1);
    else if (num_rows > ROWS_MAX) rows_eff = ROWS_MAX;
    cols_eff = num_cols;
    if (num_cols == '0)      cols_eff = CFG_W'(1);
    else if (num_cols > COLS_MAX) cols_eff = COLS_MAX;
  end

  // Position stage
  assign s0_last_col = ({1'b0, col_pos} + CFG_W'(1)) >= cols_eff;
  assign s0_last_row = ({1'b0, row_pos} + CFG_W'(1)) >= rows_eff;
  assign s1_final    = s1.valid && s1.last_col && s1.last_row;

  // Last element waits until its result slot is sure to be free
  assign in_ready = !(s0_last_col && s0_last_row) ||
                    (!s1_final && !s2_final && (!out_valid || out_ready));
  assign s0_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (s0_fire) begin
      col_pos <= s0_last_col ? '0 : col_pos + IDX_W'(1);
      if (s0_last_col) begin
        row_pos <= s0_last_row ? '0 : row_pos + IDX_W'(1);
      end
    end
  end

  // Stage 1 register: valid is reset, payload loads on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= s0_fire;
    end
    if (s0_fire) begin
      s1.col       <= col_pos;
      s1.row       <= row_pos;
      s1.first_row <= (row_pos == '0);
      s1.last_col  <= s0_last_col;
      s1.last_row  <= s0_last_row;
      s1.value     <= SUM_W'(element_value);
    end
  end

  // Column memory: read in position stage, update in stage 1
  mrcs_col_store u_col_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (s0_fire),
    .rd_col (col_pos),
    .s1     (s1),
    .csum   (csum)
  );

  // Update stage: row sum and best row/column
  assign acc_new = row_acc + s1.value;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_acc        <= '0;
      best_row_sum   <= '0;
      best_row_index <= '0;
      best_col_sum   <= '0;
      best_col_index <= '0;
    end else if (s1.valid) begin
      row_acc <= s1.last_col ? '0 : acc_new;
      if (s1.last_col && (s1.first_row || acc_new > best_row_sum)) begin
        best_row_sum   <= acc_new;
        best_row_index <= s1.row;
      end
      if (s1.last_row && (s1.col == '0 || csum > best_col_sum)) begin
        best_col_sum   <= csum;
        best_col_index <= s1.col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_final <= 1'b0;
    end else begin
      s2_final <= s1_final;
    end
  end

  // Result stage: column wins only when strictly greater
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_final) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_final) begin
      if (best_col_sum > best_row_sum) begin
        is_column    <= 1'b1;
        winner_index <= best_col_index;
        max_sum      <= best_col_sum;
      end else begin
        is_column    <= 1'b0;
        winner_index <= best_row_index;
        max_sum      <= best_row_sum;
      end
    end
  end

  // Checks
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    s2_final |-> (!out_valid || out_ready))
    else $error("result overwrites a held output item");

  a_one_final: assert property (@(posedge clk) disable iff (rst)
    !(s1_final && s2_final))
    else $error("two last elements in flight");

  a_row_clear: assert property (@(posedge clk) disable iff (rst)
    (s1.valid && s1.last_col) |=> (row_acc == '0))
    else $error("row sum not cleared at end of row");

endmodule

// ----- tb/max_row_column_sum_tb.sv -----
// max_row_column_sum_tb: self-checking bench for the max row/column sum block.
// A matrix-sum predictor forecasts each winner and a monitor compares the results.
// Depends on mrcs_pkg and the max_row_column_sum RTL.
module max_row_column_sum_tb;
  import mrcs_pkg::*;

  localparam int RANDOM_ITEMS  = 650;
  localparam int MIN_MATRICES  = 15;
  localparam int IDLE_MAX      = 8;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_LIMIT  = 10;
  localparam int CYCLE_LIMIT   = 500000;

  localparam logic signed [ELEMENT_WIDTH-1:0] ELEM_MIN = {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};
  localparam logic signed [ELEMENT_WIDTH-1:0] ELEM_MAX = {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};

  typedef enum int {MIX_WIDE, MIX_NARROW, MIX_BLEND} value_mix_t;

  typedef struct packed {
    logic                    is_column;
    logic [IDX_W-1:0]        index;
    logic signed [SUM_W-1:0] total;
  } winner_t;

  // DUT signals
  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic                            cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]            cfg_index     = REG_NUM_ROWS;
  logic [CFG_W-1:0]                cfg_data      = '0;
  logic                            in_valid      = 1'b0;
  logic                            in_ready;
  logic signed [ELEMENT_WIDTH-1:0] element_value = '0;
  logic                            out_valid;
  logic                            out_ready     = 1'b0;
  logic                            is_column;
  logic [IDX_W-1:0]                winner_index;
  logic signed [SUM_W-1:0]         max_sum;

  // Predictor state
  logic [CFG_W-1:0] rows_setting = CFG_W'(4);
  logic [CFG_W-1:0] cols_setting = CFG_W'(4);
  longint           col_totals [MAX_COLS];
  longint           row_total, best_row_total, best_col_total;
  int               row_at, col_at, best_row_at, best_col_at;
  winner_t          expected_winners [$];

  // Bench control
  int items_sent        = 0;
  int winners_predicted = 0;
  int mismatches        = 0;
  int cycle_count       = 0;
  int hold_requests     = 0;
  int holds_served      = 0;
  int hold_left         = 0;
  int stall_left        = 0;
  bit send_idle_on      = 1'b1;
  bit recv_idle_on      = 1'b1;

  max_row_column_sum uut (.*);

  always #5 clk = ~clk;

  function automatic int effective_size(logic [CFG_W-1:0] setting, int limit);
    if (setting == 0) return 1;
    if (int'(setting) > limit) return limit;
    return int'(setting);
  endfunction

  // Update running sums for one element; queue a winner on the matrix's last element
  function automatic void predict_winner(logic signed [ELEMENT_WIDTH-1:0] value);
    int      rows, cols;
    longint  x, col_sum;
    bit      last_col, last_row;
    winner_t w;
    rows     = effective_size(rows_setting, MAX_ROWS);
    cols     = effective_size(cols_setting, MAX_COLS);
    x        = longint'(value);
    col_sum  = x;
    last_col = (col_at + 1) >= cols;
    last_row = (row_at + 1) >= rows;

    if (row_at != 0) col_sum = col_totals[col_at] + x;
    col_totals[col_at] = col_sum;
    row_total += x;

    // columns are judged as they complete on the last row
    if (last_row && (col_at == 0 || col_sum > best_col_total)) begin
      best_col_total = col_sum;
      best_col_at    = col_at;
    end
    if (!last_col) begin
      col_at++;
      return;
    end

    // first row with the greatest sum wins
    if (row_at == 0 || row_total > best_row_total) begin
      best_row_total = row_total;
      best_row_at    = row_at;
    end
    row_total = 0;
    col_at    = 0;
    if (!last_row) begin
      row_at++;
      return;
    end
    row_at = 0;

    // a column must beat the best row outright
    if (best_col_total > best_row_total) begin
      w.is_column = 1'b1;
      w.index     = IDX_W'(best_col_at);
      w.total     = SUM_W'(best_col_total);
    end else begin
      w.is_column = 1'b0;
      w.index     = IDX_W'(best_row_at);
      w.total     = SUM_W'(best_row_total);
    end
    expected_winners.push_back(w);
    winners_predicted++;
  endfunction

  function automatic logic signed [ELEMENT_WIDTH-1:0] draw_element(value_mix_t mix);
    int pick;
    case (mix)
      MIX_WIDE:   pick = 0;
      MIX_NARROW: pick = 1;
      default:    pick = $urandom_range(0, 3);
    endcase
    case (pick)
      0:       return $urandom;
      1:       return ELEMENT_WIDTH'(int'($urandom_range(0, 6)) - 3);
      2:       return $urandom_range(0, 1) ? ELEM_MAX : ELEM_MIN;
      default: return $urandom_range(0, 1) ? ELEMENT_WIDTH'(0) : ELEMENT_WIDTH'(-1);
    endcase
  endfunction

  // Offer one element after a random gap; predict once it is taken
  task automatic send_element(input logic signed [ELEMENT_WIDTH-1:0] value);
    int gap;
    gap = send_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    element_value <= value;
    do @(posedge clk); while (!in_ready);
    predict_winner(value);
    items_sent++;
  endtask

  // Send elements until the predictor is back at the start of a matrix
  task automatic send_matrix(input value_mix_t mix);
    do send_element(draw_element(mix)); while (!(row_at == 0 && col_at == 0));
  endtask

  // Wait for every winner to come out and the pipeline to empty
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_winners.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_matrix_size(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    cfg_we    <= 1'b1;
    cfg_index <= REG_NUM_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_index <= REG_NUM_COLS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_we       <= 1'b0;
    rows_setting = rows;
    cols_setting = cols;
  endtask

  // ---------------------------------------------------------------- tests

  // one matrix at the sizes left by reset
  task automatic test_reset_sizes();
    send_matrix(MIX_BLEND);
  endtask

  // 1x1 matrices at the element extremes; zero sizes act as one
  task automatic test_single_elements();
    settle();
    set_matrix_size(CFG_W'(1), CFG_W'(1));
    send_element(ELEM_MIN);
    send_element(ELEM_MAX);
    settle();
    set_matrix_size(CFG_W'(0), CFG_W'(0));
    send_element(ELEMENT_WIDTH'(-1));
    send_element(ELEMENT_WIDTH'(0));
  endtask

  // equal columns (earlier wins) and a row equal to a column (row wins)
  task automatic test_ties();
    int column_tie [6] = '{1, 1, -9, 1, 1, -9};
    int row_col_tie [4] = '{1, 0, 0, 0};
    settle();
    set_matrix_size(CFG_W'(2), CFG_W'(3));
    foreach (column_tie[i]) send_element(ELEMENT_WIDTH'(column_tie[i]));
    settle();
    set_matrix_size(CFG_W'(2), CFG_W'(2));
    foreach (row_col_tie[i]) send_element(ELEMENT_WIDTH'(row_col_tie[i]));
  endtask

  // shrink sizes while a matrix is half done
  task automatic test_size_change_mid_matrix();
    settle();
    set_matrix_size(CFG_W'(3), CFG_W'(3));
    repeat (4) send_element(draw_element(MIX_NARROW));
    settle();
    set_matrix_size(CFG_W'(3), CFG_W'(2));  // column 1 now closes row 1
    send_element(draw_element(MIX_NARROW));
    settle();
    set_matrix_size(CFG_W'(2), CFG_W'(2));  // row 2 is past the new last row
    repeat (2) send_element(draw_element(MIX_NARROW));
    settle();
    set_matrix_size(CFG_W'(2), CFG_W'(4));
    repeat (6) send_element(draw_element(MIX_BLEND));
    settle();
    set_matrix_size(CFG_W'(2), CFG_W'(1));  // column 2 is past the new last column
    send_element(draw_element(MIX_BLEND));
  endtask

  // sizes above the maximum act as the maximum
  task automatic test_size_limits();
    settle();
    set_matrix_size(CFG_W'(511), CFG_W'(1));
    send_matrix(MIX_WIDE);
    settle();
    set_matrix_size(CFG_W'(1), CFG_W'(257));
    send_matrix(MIX_BLEND);
  endtask

  // receiver holds off while 1x1 matrices keep coming, so the input stalls
  task automatic test_backpressure();
    settle();
    set_matrix_size(CFG_W'(1), CFG_W'(1));
    send_idle_on = 1'b0;
    hold_requests++;
    repeat (40) send_element(draw_element(MIX_WIDE));
    send_idle_on = 1'b1;
  endtask

  // random sizes and contents, sizes changed only between matrices
  task automatic test_random();
    int               first_item, first_winner, pick;
    logic [CFG_W-1:0] rows, cols;
    first_item   = items_sent;
    first_winner = winners_predicted;
    while (items_sent - first_item < RANDOM_ITEMS ||
           winners_predicted - first_winner < MIN_MATRICES) begin
      send_idle_on = $urandom_range(0, 3) != 0;
      recv_idle_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          rows = CFG_W'($urandom_range(1, 6));
          cols = CFG_W'($urandom_range(1, 6));
        end else if (pick < 88) begin
          rows = CFG_W'($urandom_range(1, 16));
          cols = CFG_W'($urandom_range(1, 16));
        end else if (pick < 96) begin
          rows = CFG_W'($urandom_range(0, 3));
          cols = CFG_W'($urandom_range(0, 3));
        end else if (pick < 98) begin
          rows = CFG_W'($urandom_range(200, 511));
          cols = CFG_W'(1);
        end else begin
          rows = CFG_W'(1);
          cols = CFG_W'($urandom_range(200, 511));
        end
        settle();
        set_matrix_size(rows, cols);
      end
      send_matrix(value_mix_t'($urandom_range(0, 2)));
    end
  endtask

  // ---------------------------------------------------------------- processes

  // Result side: random stall after each item, plus the long hold-off on request
  always @(posedge clk) begin : drive_out_ready
    int stall_draw;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      stall_draw = recv_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      out_ready  <= (stall_draw == 0);
      stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest predicted winner
  always @(posedge clk) begin : check_winner
    winner_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_winners.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: is_column=%0b index=%0d sum=%0d",
                   is_column, winner_index, max_sum);
      end else begin
        want = expected_winners.pop_front();
        if (is_column !== want.is_column || winner_index !== want.index ||
            max_sum !== want.total) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch: expected is_column=%0b index=%0d sum=%0d, got %0b %0d %0d",
                     want.is_column, want.index, $signed(want.total),
                     is_column, winner_index, max_sum);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : run
    foreach (col_totals[i]) col_totals[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_sizes();
    test_single_elements();
    test_ties();
    test_size_change_mid_matrix();
    test_size_limits();
    test_backpressure();
    test_random();

    settle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
